// ----- sv/ole_pkg.sv -----
package ole_pkg;

	localparam int CAPACITY_DEF   = 32;
	localparam int ENTRY_BITS_DEF = 32;

	// target index width, covers 0 .. 511
	localparam int TGT_W = 9;

	typedef enum logic [2:0] {
		MODE_APPEND       = 3'd0,
		MODE_INSERT       = 3'd1,
		MODE_REMOVE_AT    = 3'd2,
		MODE_REMOVE_VALUE = 3'd3,
		MODE_FIND_FIRST   = 3'd4,
		MODE_FIND_LAST    = 3'd5,
		MODE_SET_SIZE     = 3'd6,
		MODE_CLEAR        = 3'd7
	} mode_t;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_RANGE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_APPLY
	} state_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_REMOVE,
		CELL_TRUNC,
		CELL_CLEAR
	} cell_op_t;

	typedef struct packed {
		cell_op_t         op;
		logic [TGT_W-1:0] target;
	} cell_ctl_t;

endpackage

// ----- sv/ordered_list_engine.sv -----
// Ordered list of up to CAPACITY words kept in a row of cells, one entry per
// cell, with a fill count. A request is accepted when start is high and busy
// is low; in the search state all cells compare against the value while a
// priority encoder picks the first or last hit, and in the apply state the
// cells shift, load or zero in parallel. The result shows on the output ports
// with done high for exactly one cycle, the cycle after that; busy is already
// low then, so a new request may start in that cycle, but not before the
// previous one is through. The result cannot be held off and must be taken
// when done is high. A full list or a bad position is reported in status and
// leaves the list unchanged.
module ordered_list_engine #(
	parameter int CAPACITY   = ole_pkg::CAPACITY_DEF,
	parameter int ENTRY_BITS = ole_pkg::ENTRY_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  mode,
	input  logic [5:0]  position,
	input  logic [31:0] value,
	output logic        done,
	output logic        found,
	output logic [4:0]  match_position,
	output logic [5:0]  fill_count,
	output logic [1:0]  status
);

	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int IW   = $clog2(CAPACITY);
	localparam int CMPW = (CW > 6) ? CW : 6;
	localparam int TW   = ole_pkg::TGT_W;

	ole_pkg::state_t       state_q;
	ole_pkg::state_t       state_d;
	ole_pkg::mode_t        mode_q;
	logic [5:0]            pos_q;
	logic [ENTRY_BITS-1:0] value_q;
	logic [CW-1:0]         count_q;
	logic [CW-1:0]         count_d;
	logic                  hit_q;
	logic [IW-1:0]         hit_idx_q;
	logic                  hit_any;
	logic [IW-1:0]         hit_idx;

	logic                  done_q;
	logic                  found_q;
	logic [4:0]            mpos_q;
	logic [5:0]            fill_q;
	logic [1:0]            status_q;

	logic                  found_d;
	logic [4:0]            mpos_d;
	logic [1:0]            status_d;
	logic [31:0]           mpos_w;
	logic [31:0]           fill_w;

	ole_pkg::cell_ctl_t    ctl;
	logic [ENTRY_BITS-1:0] entry [CAPACITY];
	logic [CAPACITY-1:0]   match;
	logic [CAPACITY-1:0]   mask;
	logic [CAPACITY-1:0]   hits;

	logic [CMPW-1:0]       cnt_x;
	logic [CMPW-1:0]       pos_x;
	logic [CMPW-1:0]       cap_x;
	logic [CMPW-1:0]       last_start;

	assign cnt_x = CMPW'(count_q);
	assign pos_x = CMPW'(pos_q);
	assign cap_x = CMPW'(CAPACITY);

	// cell row
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [ENTRY_BITS-1:0] lower_w;
		logic [ENTRY_BITS-1:0] upper_w;

		if (g == 0) begin : g_bot
			assign lower_w = '0;
		end else begin : g_low
			assign lower_w = entry[g-1];
		end

		if (g == CAPACITY - 1) begin : g_top
			assign upper_w = '0;
		end else begin : g_up
			assign upper_w = entry[g+1];
		end

		ole_cell #(
			.ENTRY_BITS(ENTRY_BITS),
			.IDX       (g)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.value      (value_q),
			.lower_entry(lower_w),
			.upper_entry(upper_w),
			.entry      (entry[g]),
			.match      (match[g])
		);
	end

	// search window
	always_comb begin
		last_start = (pos_x > cnt_x - CMPW'(1)) ? cnt_x - CMPW'(1) : pos_x;
		for (int i = 0; i < CAPACITY; i++) begin
			unique case (mode_q)
				ole_pkg::MODE_REMOVE_VALUE: begin
					mask[i] = (CMPW'(i) < cnt_x);
				end
				ole_pkg::MODE_FIND_FIRST: begin
					mask[i] = (CMPW'(i) < cnt_x) && (CMPW'(i) >= pos_x);
				end
				ole_pkg::MODE_FIND_LAST: begin
					mask[i] = (CMPW'(i) < cnt_x) && (CMPW'(i) <= last_start);
				end
				default: begin
					mask[i] = 1'b0;
				end
			endcase
		end
		hits = match & mask;
	end

	// priority encode
	always_comb begin
		hit_any = |hits;
		hit_idx = '0;
		if (mode_q == ole_pkg::MODE_FIND_LAST) begin
			for (int i = 0; i < CAPACITY; i++) begin
				if (hits[i]) begin
					hit_idx = IW'(i);
				end
			end
		end else begin
			for (int i = CAPACITY - 1; i >= 0; i--) begin
				if (hits[i]) begin
					hit_idx = IW'(i);
				end
			end
		end
	end

	// next state and update
	always_comb begin
		state_d    = state_q;
		ctl.op     = ole_pkg::CELL_HOLD;
		ctl.target = '0;
		count_d    = count_q;
		found_d    = 1'b0;
		status_d   = ole_pkg::STATUS_OK;
		mpos_w     = 32'(hit_idx_q);
		mpos_d     = '0;

		unique case (state_q)
			ole_pkg::ST_IDLE: begin
				if (start) begin
					state_d = ole_pkg::ST_SEARCH;
				end
			end
			ole_pkg::ST_SEARCH: begin
				state_d = ole_pkg::ST_APPLY;
			end
			ole_pkg::ST_APPLY: begin
				state_d = ole_pkg::ST_IDLE;
				unique case (mode_q)
					ole_pkg::MODE_APPEND: begin
						if (cnt_x >= cap_x) begin
							status_d = ole_pkg::STATUS_FULL;
						end else begin
							ctl.op     = ole_pkg::CELL_INSERT;
							ctl.target = TW'(cnt_x);
							count_d    = count_q + CW'(1);
						end
					end
					ole_pkg::MODE_INSERT: begin
						if (cnt_x >= cap_x) begin
							status_d = ole_pkg::STATUS_FULL;
						end else if (pos_x > cnt_x) begin
							status_d = ole_pkg::STATUS_RANGE;
						end else begin
							ctl.op     = ole_pkg::CELL_INSERT;
							ctl.target = TW'(pos_x);
							count_d    = count_q + CW'(1);
						end
					end
					ole_pkg::MODE_REMOVE_AT: begin
						if (pos_x >= cnt_x) begin
							status_d = ole_pkg::STATUS_RANGE;
						end else begin
							ctl.op     = ole_pkg::CELL_REMOVE;
							ctl.target = TW'(pos_x);
							count_d    = count_q - CW'(1);
						end
					end
					ole_pkg::MODE_REMOVE_VALUE: begin
						if (hit_q) begin
							found_d    = 1'b1;
							mpos_d     = mpos_w[4:0];
							ctl.op     = ole_pkg::CELL_REMOVE;
							ctl.target = TW'(hit_idx_q);
							count_d    = count_q - CW'(1);
						end
					end
					ole_pkg::MODE_FIND_FIRST, ole_pkg::MODE_FIND_LAST: begin
						if (hit_q) begin
							found_d = 1'b1;
							mpos_d  = mpos_w[4:0];
						end
					end
					ole_pkg::MODE_SET_SIZE: begin
						if (pos_x > cap_x) begin
							status_d = ole_pkg::STATUS_RANGE;
						end else begin
							ctl.op     = ole_pkg::CELL_TRUNC;
							ctl.target = TW'(pos_x);
							count_d    = CW'(pos_x);
						end
					end
					ole_pkg::MODE_CLEAR: begin
						ctl.op  = ole_pkg::CELL_CLEAR;
						count_d = '0;
					end
					default: begin
						state_d = ole_pkg::ST_IDLE;
					end
				endcase
			end
			default: begin
				state_d = ole_pkg::ST_IDLE;
			end
		endcase
		fill_w = 32'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ole_pkg::ST_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q  <= (state_q == ole_pkg::ST_APPLY);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ole_pkg::ST_IDLE && start) begin
			mode_q  <= ole_pkg::mode_t'(mode);
			pos_q   <= position;
			value_q <= ENTRY_BITS'(value);
		end
		if (state_q == ole_pkg::ST_SEARCH) begin
			hit_q     <= hit_any;
			hit_idx_q <= hit_idx;
		end
		if (state_q == ole_pkg::ST_APPLY) begin
			found_q  <= found_d;
			mpos_q   <= mpos_d;
			fill_q   <= fill_w[5:0];
			status_q <= status_d;
		end
	end

	assign busy           = (state_q != ole_pkg::ST_IDLE);
	assign done           = done_q;
	assign found          = found_q;
	assign match_position = mpos_q;
	assign fill_count     = fill_q;
	assign status         = status_q;

endmodule

// ----- sv/ole_cell.sv -----
module ole_cell #(
	parameter int ENTRY_BITS = ole_pkg::ENTRY_BITS_DEF,
	parameter int IDX        = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ole_pkg::cell_ctl_t    ctl,
	input  logic [ENTRY_BITS-1:0] value,
	input  logic [ENTRY_BITS-1:0] lower_entry,
	input  logic [ENTRY_BITS-1:0] upper_entry,
	output logic [ENTRY_BITS-1:0] entry,
	output logic                  match
);

	localparam logic [ole_pkg::TGT_W-1:0] MY_IDX = ole_pkg::TGT_W'(IDX);

	logic [ENTRY_BITS-1:0] entry_q;
	logic [ENTRY_BITS-1:0] entry_d;

	always_comb begin
		entry_d = entry_q;
		unique case (ctl.op)
			ole_pkg::CELL_HOLD: begin
				entry_d = entry_q;
			end
			ole_pkg::CELL_INSERT: begin
				if (MY_IDX > ctl.target) begin
					entry_d = lower_entry;
				end else if (MY_IDX == ctl.target) begin
					entry_d = value;
				end
			end
			ole_pkg::CELL_REMOVE: begin
				if (MY_IDX >= ctl.target) begin
					entry_d = upper_entry;
				end
			end
			ole_pkg::CELL_TRUNC: begin
				if (MY_IDX >= ctl.target) begin
					entry_d = '0;
				end
			end
			ole_pkg::CELL_CLEAR: begin
				entry_d = '0;
			end
			default: begin
				entry_d = entry_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else begin
			entry_q <= entry_d;
		end
	end

	assign entry = entry_q;
	assign match = (entry_q == value);

endmodule
